>>> design/cotab_pkg.sv
// Shared types and constants of the count-ordered self-organising table.
`default_nettype none

package cotab_pkg;

  localparam int unsigned KeyWidth      = 32;
  localparam int unsigned CapacityDef   = 16;
  localparam int unsigned CountWidthDef = 16;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } cotab_status_e;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_SEARCH = 1'b1
  } cotab_cmd_e;

  typedef struct packed {
    logic load_new;
    logic shift;
  } cotab_cell_ctl_t;

endpackage

`default_nettype wire

>>> design/cotab_req_if.sv
// Request channel: command and key, valid/ready handshake.
`default_nettype none

interface cotab_req_if;
  import cotab_pkg::*;

  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic signed [KeyWidth-1:0]  key;

  modport source (output valid, output cmd, output key, input ready);
  modport sink   (input valid, input cmd, input key, output ready);
endinterface

`default_nettype wire

>>> design/cotab_rsp_if.sv
// Response channel: status, valid/ready handshake.
`default_nettype none

interface cotab_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;

  modport source (output valid, output status, input ready);
  modport sink   (input valid, input status, output ready);
endinterface

`default_nettype wire

>>> design/cotab_cell.sv
// One table cell: holds a key and its count, compares, shifts from its neighbour.
`default_nettype none

module cotab_cell
  import cotab_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  wire logic                          clk_i,
  input  wire cotab_cell_ctl_t               ctl_i,
  input  wire logic [KeyWidth-1:0]           new_key_i,
  input  wire logic [COUNT_WIDTH-1:0]        new_cnt_i,
  input  wire logic [KeyWidth-1:0]           prev_key_i,
  input  wire logic [COUNT_WIDTH-1:0]        prev_cnt_i,
  input  wire logic [KeyWidth-1:0]           cmp_key_i,
  input  wire logic [COUNT_WIDTH-1:0]        cmp_cnt_i,
  output logic [KeyWidth-1:0]                key_o,
  output logic [COUNT_WIDTH-1:0]             cnt_o,
  output logic                               match_o,
  output logic                               le_o
);

  logic [KeyWidth-1:0]    key_q;
  logic [COUNT_WIDTH-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_new) begin
      key_q <= new_key_i;
      cnt_q <= new_cnt_i;
    end else if (ctl_i.shift) begin
      key_q <= prev_key_i;
      cnt_q <= prev_cnt_i;
    end
  end

  assign key_o   = key_q;
  assign cnt_o   = cnt_q;
  assign match_o = (key_q == cmp_key_i);
  assign le_o    = (cnt_q <= cmp_cnt_i);

endmodule

`default_nettype wire

>>> design/count_ordered_self_organizing_table_unit.sv
// Top level of the count-ordered self-organising table: cell chain and sequencer.
//
// Usage: req_i carries one beat per operation (cmd, key); rsp_o returns exactly
// one beat per request with a status (inserted, found, not found, table full).
// An insert appends the key with count zero at the tail. A search looks for the
// first matching entry from the front, bumps its saturating count and moves it
// in front of the first entry whose count is not greater, the rest shifting back.
// Sequence: request accepted, a compare state over all cells (insert writes
// here), a move state for a found search, then the response register loads.
// One request is processed at a time: a new request is taken only once the
// previous one has loaded its response and the sequencer is idle again; the
// single cell chain does both the compare and the move.
// Reset clears the fill count and the control state; the cell contents are not
// cleared, and only cells below the fill count are ever consulted.
// A stalled receiver holds the response; one further request is still taken and
// processed, then waits in the response state until the held beat is taken, and
// no request beyond it is accepted meanwhile.
`default_nettype none

module count_ordered_self_organizing_table_unit
  import cotab_pkg::*;
#(
  parameter int unsigned CAPACITY    = CapacityDef,
  parameter int unsigned COUNT_WIDTH = CountWidthDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cotab_req_if.sink  req_i,
  cotab_rsp_if.source rsp_o
);

  localparam int unsigned UsedWidth = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_MOVE,
    S_RESP
  } state_e;

  state_e                  state_q;
  logic                    cmd_q;
  logic [KeyWidth-1:0]     key_q;
  logic [UsedWidth-1:0]    used_q;
  logic [CAPACITY-1:0]     hit_q;
  logic [CAPACITY-1:0]     pre_q;
  logic [COUNT_WIDTH-1:0]  cnt_new_q;
  cotab_status_e           st_q;
  logic                    rsp_valid_q;
  cotab_status_e           rsp_status_q;

  logic [KeyWidth-1:0]     cell_key  [CAPACITY];
  logic [COUNT_WIDTH-1:0]  cell_cnt  [CAPACITY];
  logic [CAPACITY-1:0]     cell_match;
  logic [CAPACITY-1:0]     cell_le;
  logic [CAPACITY-1:0]     cell_vld;
  cotab_cell_ctl_t         cell_ctl  [CAPACITY];

  logic [CAPACITY-1:0]     match_vec;
  logic [CAPACITY-1:0]     hit_d;
  logic [CAPACITY-1:0]     pre_d;
  logic [COUNT_WIDTH-1:0]  cnt_sel;
  logic [COUNT_WIDTH-1:0]  cnt_new_d;
  logic [CAPACITY-1:0]     le_vec;
  logic [CAPACITY-1:0]     dst_vec;
  logic [CAPACITY-1:0]     after_dst;
  logic [COUNT_WIDTH-1:0]  new_cnt;
  logic                    full;
  logic                    rsp_free;

  assign full     = (used_q == UsedWidth'(CAPACITY));
  assign rsp_free = !rsp_valid_q || rsp_o.ready;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_vld
    assign cell_vld[i] = (UsedWidth'(i) < used_q);
  end

  // Compare stage: first hit from the front and the cells in front of it.
  assign match_vec = cell_match & cell_vld;
  assign hit_d     = match_vec & (~match_vec + CAPACITY'(1));
  assign pre_d     = ~match_vec & (match_vec - CAPACITY'(1));

  always_comb begin
    cnt_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      cnt_sel = cnt_sel | (cell_cnt[i] & {COUNT_WIDTH{hit_d[i]}});
    end
  end

  assign cnt_new_d = (cnt_sel == {COUNT_WIDTH{1'b1}}) ? cnt_sel
                                                      : cnt_sel + COUNT_WIDTH'(1);

  // Move stage: first cell in front of the hit whose count is not greater.
  assign le_vec    = cell_le & pre_q;
  assign dst_vec   = le_vec & (~le_vec + CAPACITY'(1));
  assign after_dst = ~(le_vec ^ (le_vec - CAPACITY'(1)));

  assign new_cnt = (state_q == S_CMP) ? '0 : cnt_new_q;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_ctl[i] = '0;
      if (state_q == S_CMP && cmd_q == CMD_INSERT && !full) begin
        cell_ctl[i].load_new = (used_q == UsedWidth'(i));
      end else if (state_q == S_MOVE) begin
        cell_ctl[i].load_new = dst_vec[i] | (hit_q[i] & ~|le_vec);
        cell_ctl[i].shift    = after_dst[i] & (pre_q[i] | hit_q[i]);
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KeyWidth-1:0]    prev_key;
    logic [COUNT_WIDTH-1:0] prev_cnt;

    if (i == 0) begin : g_head
      assign prev_key = '0;
      assign prev_cnt = '0;
    end else begin : g_body
      assign prev_key = cell_key[i-1];
      assign prev_cnt = cell_cnt[i-1];
    end

    cotab_cell #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_cell (
      .clk_i      (clk_i),
      .ctl_i      (cell_ctl[i]),
      .new_key_i  (key_q),
      .new_cnt_i  (new_cnt),
      .prev_key_i (prev_key),
      .prev_cnt_i (prev_cnt),
      .cmp_key_i  (key_q),
      .cmp_cnt_i  (cnt_new_q),
      .key_o      (cell_key[i]),
      .cnt_o      (cell_cnt[i]),
      .match_o    (cell_match[i]),
      .le_o       (cell_le[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      used_q       <= '0;
      rsp_valid_q  <= 1'b0;
      rsp_status_q <= ST_INSERTED;
      st_q         <= ST_INSERTED;
    end else begin
      if (rsp_valid_q && rsp_o.ready && state_q != S_RESP) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          if (cmd_q == CMD_INSERT) begin
            if (full) begin
              st_q <= ST_FULL;
            end else begin
              st_q   <= ST_INSERTED;
              used_q <= used_q + UsedWidth'(1);
            end
            state_q <= S_RESP;
          end else if (|match_vec) begin
            state_q <= S_MOVE;
          end else begin
            st_q    <= ST_NOT_FOUND;
            state_q <= S_RESP;
          end
        end
        S_MOVE: begin
          st_q    <= ST_FOUND;
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (rsp_free) begin
            rsp_valid_q  <= 1'b1;
            rsp_status_q <= st_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req_i.valid) begin
      cmd_q <= req_i.cmd;
      key_q <= req_i.key;
    end
    if (state_q == S_CMP) begin
      hit_q     <= hit_d;
      pre_q     <= pre_d;
      cnt_new_q <= cnt_new_d;
    end
  end

  assign req_i.ready  = (state_q == S_IDLE);
  assign rsp_o.valid  = rsp_valid_q;
  assign rsp_o.status = rsp_status_q;

endmodule

`default_nettype wire
